@@ sv/aas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC average sequencer package
// Shared constants, channel codes and the command record passed from the
// sequencer front end to the result back end.
// ----------------------------------------------------------------------------
package aas_pkg;

	localparam int SAMPLES_PER_MEASURE = 4;
	localparam int SAMPLE_BITS         = 12;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 5;
	localparam int MV_W     = 15;
	localparam int MA_W     = 16;
	localparam int PW_W     = 20;

	localparam logic [2:0] REQ_V = 3'b001;
	localparam logic [2:0] REQ_I = 3'b010;
	localparam logic [2:0] REQ_D = 3'b100;

	localparam logic [1:0] CH_NONE    = 2'd0;
	localparam logic [1:0] CH_VOLTAGE = 2'd1;
	localparam logic [1:0] CH_CURRENT = 2'd2;

	localparam logic [2:0] VOLT_SCALE     = 3'd5;
	localparam logic [3:0] CUR_SCALE_LOW  = 4'd5;
	localparam logic [3:0] CUR_SCALE_HIGH = 4'd10;

	localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};
	localparam logic [MA_W-1:0] MA_MAX = {MA_W{1'b1}};
	localparam logic [PW_W-1:0] PW_MAX = {PW_W{1'b1}};

	// Divide by 1000 as a shift by 3 and a reciprocal multiply by 1/125
	localparam int PROD_W       = MV_W + MA_W;
	localparam int DIV_SHIFT    = 3;
	localparam int Y_W          = PROD_W - DIV_SHIFT;
	localparam int DIV_ODD      = 125;
	localparam int RECIP_W      = 22;
	localparam int RECIP_SHIFT  = Y_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD);
	localparam int RPROD_W      = Y_W + RECIP_W;
	localparam int QUOT_W       = RPROD_W - RECIP_SHIFT;

	localparam logic [3:0] CFG_ADDR_RANGE = 4'd0;

	typedef struct packed {
		logic [1:0]       select_channel;
		logic             start_conversion;
		logic             done_res;
		logic [SUM_W-1:0] voltage_sum;
		logic [SUM_W-1:0] current_sum;
		logic             range_high;
	} cmd_t;

endpackage
`default_nettype wire

@@ sv/aas_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC average sequencer front end
// Runs the tick sequencer: latches requests, selects channels, counts
// conversions, accumulates sums and emits one command per tick.
// ----------------------------------------------------------------------------
module aas_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire                          request_voltage,
	input  wire                          request_current,
	input  wire                          request_disconnect,
	input  wire [aas_pkg::SAMPLE_W-1:0]  adc_sample,
	input  wire                          range_high,
	output aas_pkg::cmd_t                cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DISPATCH = 6'b000010,
		ST_SEL_V    = 6'b000100,
		ST_RUN_V    = 6'b001000,
		ST_SEL_I    = 6'b010000,
		ST_RUN_I    = 6'b100000
	} seq_state_t;

	seq_state_t                  state_q, state_n;
	logic [2:0]                  pend_q, pend_n;
	logic [aas_pkg::CNT_W-1:0]   cnt_q, cnt_n;
	logic [aas_pkg::SUM_W-1:0]   vsum_q, vsum_n;
	logic [aas_pkg::SUM_W-1:0]   isum_q, isum_n;
	logic [aas_pkg::SUM_W-1:0]   sample;
	logic [2:0]                  req;
	logic                        take;

	assign sample = aas_pkg::SUM_W'(adc_sample[aas_pkg::SAMPLE_BITS-1:0]);
	assign req    = {request_disconnect, request_current, request_voltage};
	assign take   = cnt_q < aas_pkg::CNT_W'(aas_pkg::SAMPLES_PER_MEASURE);

	always_comb begin
		state_n = state_q;
		pend_n  = pend_q;
		cnt_n   = cnt_q;
		vsum_n  = vsum_q;
		isum_n  = isum_q;
		cmd.select_channel   = aas_pkg::CH_NONE;
		cmd.start_conversion = 1'b0;
		cmd.done_res         = 1'b0;
		cmd.voltage_sum      = vsum_q;
		cmd.current_sum      = isum_q;
		cmd.range_high       = range_high;
		case (state_q)
			ST_IDLE: begin
				pend_n = req;
				if (req != 3'b000)
					state_n = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if ((pend_q & (aas_pkg::REQ_V | aas_pkg::REQ_D)) == aas_pkg::REQ_V) begin
					pend_n  = pend_q & ~(aas_pkg::REQ_V | aas_pkg::REQ_D);
					vsum_n  = '0;
					state_n = ST_SEL_V;
				end else if ((pend_q & aas_pkg::REQ_I) != 3'b000) begin
					pend_n  = pend_q & ~aas_pkg::REQ_I;
					isum_n  = '0;
					state_n = ST_SEL_I;
				end else begin
					cmd.done_res = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			ST_SEL_V: begin
				cmd.select_channel = aas_pkg::CH_VOLTAGE;
				cnt_n   = aas_pkg::CNT_W'(aas_pkg::SAMPLES_PER_MEASURE);
				state_n = ST_RUN_V;
			end
			ST_RUN_V: begin
				if (take)
					vsum_n = vsum_q + sample;
				if (cnt_q != '0) begin
					cmd.start_conversion = 1'b1;
					cnt_n = cnt_q - 1'b1;
				end else begin
					state_n = ST_DISPATCH;
				end
			end
			ST_SEL_I: begin
				cmd.select_channel = aas_pkg::CH_CURRENT;
				cnt_n   = aas_pkg::CNT_W'(aas_pkg::SAMPLES_PER_MEASURE);
				state_n = ST_RUN_I;
			end
			ST_RUN_I: begin
				if (take)
					isum_n = isum_q + sample;
				if (cnt_q != '0) begin
					cmd.start_conversion = 1'b1;
					cnt_n = cnt_q - 1'b1;
				end else begin
					state_n = ST_DISPATCH;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			cnt_q   <= '0;
			vsum_q  <= '0;
			isum_q  <= '0;
		end else if (accept) begin
			state_q <= state_n;
			pend_q  <= pend_n;
			cnt_q   <= cnt_n;
			vsum_q  <= vsum_n;
			isum_q  <= isum_n;
		end
	end

endmodule
`default_nettype wire

@@ sv/aas_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC average sequencer command queue
// Two-entry queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module aas_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_en,
	input  aas_pkg::cmd_t  wr_data,
	output logic           full,
	input  wire            rd_en,
	output aas_pkg::cmd_t  rd_data,
	output logic           empty
);

	aas_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/aas_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADC average sequencer back end
// Takes commands from the queue, scales the averages, forms the power
// over several cycles and holds each result transaction until popped.
// ----------------------------------------------------------------------------
module aas_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  aas_pkg::cmd_t               cmd,
	input  wire                         cmd_empty,
	output logic                        cmd_pop,
	input  wire                         pop,
	output logic                        empty,
	output logic [1:0]                  select_channel,
	output logic                        start_conversion,
	output logic                        done_res,
	output logic [aas_pkg::MV_W-1:0]    voltage_mv,
	output logic [aas_pkg::MA_W-1:0]    current_ma,
	output logic [aas_pkg::PW_W-1:0]    power_mw
);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_SCALE = 5'b00010,
		B_MUL   = 5'b00100,
		B_RECIP = 5'b01000,
		B_FIX   = 5'b10000
	} back_state_t;

	back_state_t                   state_q;
	aas_pkg::cmd_t                 cmd_q;
	logic [aas_pkg::MV_W-1:0]      mv_q;
	logic [aas_pkg::MA_W-1:0]      ma_q;
	logic [aas_pkg::PROD_W-1:0]    prod_q;
	logic [aas_pkg::Y_W-1:0]       y_q;
	logic [aas_pkg::RPROD_W-1:0]   rprod_q;
	logic                          out_valid_q;
	logic [1:0]                    sel_q;
	logic                          start_q;
	logic                          done_q;
	logic [aas_pkg::MV_W-1:0]      mv_out_q;
	logic [aas_pkg::MA_W-1:0]      ma_out_q;
	logic [aas_pkg::PW_W-1:0]      pw_out_q;

	logic                          out_free;
	logic [aas_pkg::SUM_W-1:0]     vavg;
	logic [aas_pkg::SUM_W-1:0]     iavg;
	logic [aas_pkg::SUM_W+2:0]     mv_full;
	logic [aas_pkg::SUM_W+3:0]     ma_full;
	logic [3:0]                    cur_scale;
	logic [aas_pkg::QUOT_W-1:0]    quot0;
	logic [aas_pkg::Y_W-1:0]       rem;
	logic [aas_pkg::QUOT_W-1:0]    quot;

	assign out_free = !out_valid_q || pop;
	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty && out_free;

	assign vavg      = aas_pkg::SUM_W'(cmd_q.voltage_sum / aas_pkg::SAMPLES_PER_MEASURE);
	assign iavg      = aas_pkg::SUM_W'(cmd_q.current_sum / aas_pkg::SAMPLES_PER_MEASURE);
	assign cur_scale = cmd_q.range_high ? aas_pkg::CUR_SCALE_HIGH : aas_pkg::CUR_SCALE_LOW;
	assign mv_full   = (aas_pkg::SUM_W+3)'(vavg) * (aas_pkg::SUM_W+3)'(aas_pkg::VOLT_SCALE);
	assign ma_full   = (aas_pkg::SUM_W+4)'(iavg) * (aas_pkg::SUM_W+4)'(cur_scale);

	assign quot0 = rprod_q[aas_pkg::RPROD_W-1:aas_pkg::RECIP_SHIFT];
	assign rem   = y_q - aas_pkg::Y_W'(quot0) * aas_pkg::Y_W'(aas_pkg::DIV_ODD);
	assign quot  = (rem >= aas_pkg::Y_W'(aas_pkg::DIV_ODD)) ? quot0 + 1'b1 : quot0;

	assign empty            = !out_valid_q;
	assign select_channel   = sel_q;
	assign start_conversion = start_q;
	assign done_res         = done_q;
	assign voltage_mv       = mv_out_q;
	assign current_ma       = ma_out_q;
	assign power_mw         = pw_out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cmd_q <= cmd;
			end
			B_SCALE: begin
				mv_q <= (mv_full > (aas_pkg::SUM_W+3)'(aas_pkg::MV_MAX)) ?
					aas_pkg::MV_MAX : aas_pkg::MV_W'(mv_full);
				ma_q <= (ma_full > (aas_pkg::SUM_W+4)'(aas_pkg::MA_MAX)) ?
					aas_pkg::MA_MAX : aas_pkg::MA_W'(ma_full);
			end
			B_MUL: begin
				prod_q <= aas_pkg::PROD_W'(mv_q) * aas_pkg::PROD_W'(ma_q);
			end
			B_RECIP: begin
				y_q     <= prod_q[aas_pkg::PROD_W-1:aas_pkg::DIV_SHIFT];
				rprod_q <= aas_pkg::RPROD_W'(prod_q[aas_pkg::PROD_W-1:aas_pkg::DIV_SHIFT])
					* aas_pkg::RPROD_W'(aas_pkg::RECIP_MUL);
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			sel_q       <= '0;
			start_q     <= 1'b0;
			done_q      <= 1'b0;
			mv_out_q    <= '0;
			ma_out_q    <= '0;
			pw_out_q    <= '0;
		end else begin
			if (pop && out_valid_q && !(cmd_pop && !cmd.done_res))
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						if (cmd.done_res) begin
							state_q <= B_SCALE;
						end else begin
							out_valid_q <= 1'b1;
							sel_q       <= cmd.select_channel;
							start_q     <= cmd.start_conversion;
							done_q      <= 1'b0;
							mv_out_q    <= '0;
							ma_out_q    <= '0;
							pw_out_q    <= '0;
						end
					end
				end
				B_SCALE: state_q <= B_MUL;
				B_MUL:   state_q <= B_RECIP;
				B_RECIP: state_q <= B_FIX;
				B_FIX: begin
					out_valid_q <= 1'b1;
					sel_q       <= aas_pkg::CH_NONE;
					start_q     <= 1'b0;
					done_q      <= 1'b1;
					mv_out_q    <= mv_q;
					ma_out_q    <= ma_q;
					pw_out_q    <= (quot > aas_pkg::QUOT_W'(aas_pkg::PW_MAX)) ?
						aas_pkg::PW_MAX : aas_pkg::PW_W'(quot);
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/adc_average_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: a plain tick's transaction is registered onto the result port when the
//   back end pops it from the queue; a done tick's passes through queue pop, scale,
//   multiply, reciprocal multiply and correction in the back end.
// Throughput: one tick per cycle while the queue is not full; the back end pops
//   no command while its multi-cycle power unit works on a done tick.
// Reset: arst_n clears the sequencer to idle, all sums and the range bit to 0.
// ----------------------------------------------------------------------------
// ADC average sequencer core
// Tick-driven ADC averaging sequencer with queue-style ports and an APB-style
// configuration register for the current range.
// ----------------------------------------------------------------------------
module adc_average_sequencer_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [3:0]                   paddr,
	input  wire [31:0]                  pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire                         push,
	output logic                        full,
	input  wire                         request_voltage,
	input  wire                         request_current,
	input  wire                         request_disconnect,
	input  wire [aas_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                        empty,
	input  wire                         pop,
	output logic [1:0]                  select_channel,
	output logic                        start_conversion,
	output logic                        done_res,
	output logic [aas_pkg::MV_W-1:0]    voltage_mv,
	output logic [aas_pkg::MA_W-1:0]    current_ma,
	output logic [aas_pkg::PW_W-1:0]    power_mw
);

	logic          range_high_q;
	logic          accept;
	logic          q_empty;
	logic          q_pop;
	aas_pkg::cmd_t front_cmd;
	aas_pkg::cmd_t back_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == aas_pkg::CFG_ADDR_RANGE) ? 32'(range_high_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			range_high_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr == aas_pkg::CFG_ADDR_RANGE)
			range_high_q <= pwdata[0];
	end

	assign accept = push && !full;

	aas_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.request_voltage    (request_voltage),
		.request_current    (request_current),
		.request_disconnect (request_disconnect),
		.adc_sample         (adc_sample),
		.range_high         (range_high_q),
		.cmd                (front_cmd)
	);

	aas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (back_cmd),
		.empty   (q_empty)
	);

	aas_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (back_cmd),
		.cmd_empty        (q_empty),
		.cmd_pop          (q_pop),
		.pop              (pop),
		.empty            (empty),
		.select_channel   (select_channel),
		.start_conversion (start_conversion),
		.done_res         (done_res),
		.voltage_mv       (voltage_mv),
		.current_ma       (current_ma),
		.power_mw         (power_mw)
	);

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> (select_channel == aas_pkg::CH_NONE && !start_conversion))
		else $error("done transaction carries a channel select or start");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !done_res) |-> (voltage_mv == '0 && current_ma == '0 && power_mw == '0))
		else $error("plain transaction carries measurement values");

	a_select_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && select_channel != aas_pkg::CH_NONE) |-> !start_conversion)
		else $error("channel select and conversion start in one transaction");

	a_power_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> (power_mw <= 20'd838451))
		else $error("power beyond product of saturated voltage and current");

endmodule
`default_nettype wire
